[hdl/ntsc_pkg.sv]
package ntsc_pkg;

	// Geometry of the search window and the sentence buffer
	localparam int TAG_LEN      = 6;
	localparam int TAG_W        = TAG_LEN * 8;
	localparam int SENTENCE_MAX = 128;

	// Register widths
	localparam int PATTERN_W = 48;
	localparam int TIMEOUT_W = 16;
	localparam int FIELD_W   = 5;
	localparam int CNT_W     = 8;

	// Register indexes
	localparam logic [1:0] CFG_TAG_PATTERN  = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT_MS   = 2'd1;
	localparam logic [1:0] CFG_FIELD_SELECT = 2'd2;

	// Register reset values ("$GPGGA", 5000 ticks, field 0)
	localparam logic [PATTERN_W-1:0] TAG_PATTERN_RST  = 48'h24_47_50_47_47_41;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST   = 16'd5000;
	localparam logic [FIELD_W-1:0]   FIELD_SELECT_RST = 5'd0;

	// Commands
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Result events
	localparam logic [2:0] EV_FOUND    = 3'd0;
	localparam logic [2:0] EV_BYTE     = 3'd1;
	localparam logic [2:0] EV_END      = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;

	// Characters
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;

	typedef struct packed {
		logic [PATTERN_W-1:0] tag_pattern;
		logic [TIMEOUT_W-1:0] timeout_ms;
		logic [FIELD_W-1:0]   field_select;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [7:0]         data_byte;
		logic [FIELD_W-1:0] field_number;
		logic               is_delimiter;
		logic               in_selected;
		logic               last;
	} res_t;

	// Low TAG_W bits of the pattern, zero above the register width
	function automatic logic [TAG_W-1:0] tag_compare_value(input logic [PATTERN_W-1:0] p);
		logic [63:0] wide;
		wide = 64'(p);
		return wide[TAG_W-1:0];
	endfunction

endpackage

[hdl/ntsc_cfg_regs.sv]
module ntsc_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [47:0]         cfg_data,
	output ntsc_pkg::cfg_t      cfg
);

	ntsc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tag_pattern  <= ntsc_pkg::TAG_PATTERN_RST;
			cfg_q.timeout_ms   <= ntsc_pkg::TIMEOUT_MS_RST;
			cfg_q.field_select <= ntsc_pkg::FIELD_SELECT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ntsc_pkg::CFG_TAG_PATTERN: begin
					cfg_q.tag_pattern <= cfg_data[ntsc_pkg::PATTERN_W-1:0];
				end
				ntsc_pkg::CFG_TIMEOUT_MS: begin
					cfg_q.timeout_ms <= cfg_data[ntsc_pkg::TIMEOUT_W-1:0];
				end
				ntsc_pkg::CFG_FIELD_SELECT: begin
					cfg_q.field_select <= cfg_data[ntsc_pkg::FIELD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/ntsc_core.sv]
module ntsc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  ntsc_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     command,
	input  logic [7:0]     rx_byte,
	input  logic           res_space,
	output logic           res_push,
	output ntsc_pkg::res_t res
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_SEARCH  = 2'd1;
	localparam logic [1:0] PH_CAPTURE = 2'd2;

	localparam logic [ntsc_pkg::CNT_W-1:0] TAG_CNT  = ntsc_pkg::CNT_W'(ntsc_pkg::TAG_LEN);
	localparam logic [ntsc_pkg::CNT_W-1:0] FULL_CNT =
		ntsc_pkg::CNT_W'(ntsc_pkg::SENTENCE_MAX - 1);

	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;

	logic [1:0]                      phase_q, phase_n;
	logic [ntsc_pkg::TAG_W-1:0]      window_q, window_n;
	logic [ntsc_pkg::TIMEOUT_W-1:0]  ticks_q, ticks_n;
	logic [ntsc_pkg::FIELD_W-1:0]    comma_q, comma_n;
	logic [ntsc_pkg::CNT_W-1:0]      count_q, count_n;
	logic                            res_valid;
	logic                            is_comma;

	assign advance  = valid_s1 && res_space;
	assign in_ready = !valid_s1 || res_space;
	assign res_push = advance && res_valid;
	assign is_comma = (rx_byte_s1 == ntsc_pkg::CHAR_COMMA);

	// Hold the accepted word until the result side has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	// Next state and result for the word in the input register
	always_comb begin
		phase_n   = phase_q;
		window_n  = window_q;
		ticks_n   = ticks_q;
		comma_n   = comma_q;
		count_n   = count_q;
		res_valid = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		case (command_s1)
			ntsc_pkg::CMD_START: begin
				phase_n  = PH_SEARCH;
				window_n = '0;
				ticks_n  = '0;
				comma_n  = '0;
				count_n  = '0;
			end
			ntsc_pkg::CMD_BYTE: begin
				if (phase_q == PH_SEARCH) begin
					window_n = (window_q << 8) | ntsc_pkg::TAG_W'(rx_byte_s1);
					if (count_q < TAG_CNT) begin
						count_n = count_q + 1'b1;
					end
					if (count_n >= TAG_CNT && window_n ==
						ntsc_pkg::tag_compare_value(cfg.tag_pattern)) begin
						phase_n       = PH_CAPTURE;
						comma_n       = '0;
						count_n       = TAG_CNT;
						res_valid     = 1'b1;
						res.event_res = ntsc_pkg::EV_FOUND;
					end
				end else if (phase_q == PH_CAPTURE) begin
					res_valid = 1'b1;
					if (rx_byte_s1 == ntsc_pkg::CHAR_NEWLINE) begin
						phase_n       = PH_IDLE;
						res.event_res = ntsc_pkg::EV_END;
					end else if (count_q >= FULL_CNT) begin
						phase_n       = PH_IDLE;
						res.event_res = ntsc_pkg::EV_OVERFLOW;
					end else begin
						count_n          = count_q + 1'b1;
						res.event_res    = ntsc_pkg::EV_BYTE;
						res.data_byte    = rx_byte_s1;
						res.field_number = comma_q;
						res.is_delimiter = is_comma;
						res.in_selected  = !is_comma && (comma_q == cfg.field_select);
						res.last         = 1'b0;
						if (is_comma && comma_q != '1) begin
							comma_n = comma_q + 1'b1;
						end
					end
				end
			end
			ntsc_pkg::CMD_TICK: begin
				if (phase_q == PH_SEARCH) begin
					if (ticks_q != '1) begin
						ticks_n = ticks_q + 1'b1;
					end
					if (ticks_n >= cfg.timeout_ms) begin
						phase_n       = PH_IDLE;
						res_valid     = 1'b1;
						res.event_res = ntsc_pkg::EV_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the search and capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			window_q <= '0;
			ticks_q  <= '0;
			comma_q  <= '0;
			count_q  <= '0;
		end else if (advance) begin
			phase_q  <= phase_n;
			window_q <= window_n;
			ticks_q  <= ticks_n;
			comma_q  <= comma_n;
			count_q  <= count_n;
		end
	end

`ifndef SYNTHESIS
	a_capture_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CAPTURE |-> count_q >= TAG_CNT && count_q <= FULL_CNT)
		else $error("capture count out of range");

	a_search_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> count_q <= TAG_CNT)
		else $error("search count beyond tag length");

	a_found_enters_capture: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.event_res == ntsc_pkg::EV_FOUND |=> phase_q == PH_CAPTURE)
		else $error("tag found without entering capture");

	a_byte_only_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.event_res == ntsc_pkg::EV_BYTE |-> phase_q == PH_CAPTURE)
		else $error("sentence byte outside capture");
`endif

endmodule

[hdl/ntsc_out_fifo.sv]
module ntsc_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ntsc_pkg::res_t push_data,
	output logic           space,
	output logic           out_valid,
	input  logic           out_ready,
	output ntsc_pkg::res_t head
);

	ntsc_pkg::res_t mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign head      = mem[rd_q];

	// Store results in arrival order
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/nmea_tag_sentence_capture.sv]
// Path: an accepted word is held in the input register, and any result word that
// it yields is written into the two-entry output queue once the queue has room;
// the head of that queue drives the output ports.
// Throughput: one word per cycle while the output queue has room; else the input stalls.
// Reset (arst_n low): idle, counters and window cleared, registers take
// their default values ($GPGGA, 5000 ticks, field 0), output queue empty.
module nmea_tag_sentence_capture (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [4:0]  field_number,
	output logic        is_delimiter,
	output logic        in_selected,
	output logic        last
);

	ntsc_pkg::cfg_t cfg;
	ntsc_pkg::res_t res;
	ntsc_pkg::res_t head;
	logic           res_push;
	logic           res_space;

	ntsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ntsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.rx_byte   (rx_byte),
		.res_space (res_space),
		.res_push  (res_push),
		.res       (res)
	);

	ntsc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.space     (res_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign event_res    = head.event_res;
	assign data_byte    = head.data_byte;
	assign field_number = head.field_number;
	assign is_delimiter = head.is_delimiter;
	assign in_selected  = head.in_selected;
	assign last         = head.last;

endmodule

[sim/capture_checker.sv]
`timescale 1ns / 1ps

module capture_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  event_res,
	input  logic [7:0]  data_byte,
	input  logic [4:0]  field_number,
	input  logic        is_delimiter,
	input  logic        in_selected,
	input  logic        last,
	output int          outstanding,
	output int          mismatches
);

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_SEARCH, SCAN_CAPTURE} scan_phase_t;

	// Shadow registers
	logic [ntsc_pkg::PATTERN_W-1:0] tag_cfg;
	logic [ntsc_pkg::TIMEOUT_W-1:0] timeout_cfg;
	logic [ntsc_pkg::FIELD_W-1:0]   select_cfg;

	// Shadow sentence state
	scan_phase_t                    scan_phase;
	logic [ntsc_pkg::TAG_W-1:0]     window;
	logic [ntsc_pkg::TIMEOUT_W-1:0] ticks;
	logic [ntsc_pkg::FIELD_W-1:0]   commas;
	logic [ntsc_pkg::CNT_W-1:0]     kept;

	ntsc_pkg::res_t expected_events[$];

	function automatic ntsc_pkg::res_t closing_event(input logic [2:0] ev);
		ntsc_pkg::res_t r;
		r = '0;
		r.event_res = ev;
		r.last = 1'b1;
		return r;
	endfunction

	// Advance the shadow state by one word; return 1 when it yields an event
	function automatic bit capture_step(input logic [1:0] cmd, input logic [7:0] b,
			output ntsc_pkg::res_t r);
		r = '0;
		case (cmd)
			ntsc_pkg::CMD_START: begin
				scan_phase = SCAN_SEARCH;
				window = '0;
				ticks = '0;
				commas = '0;
				kept = '0;
			end
			ntsc_pkg::CMD_BYTE: begin
				if (scan_phase == SCAN_SEARCH) begin
					window = (window << 8) | ntsc_pkg::TAG_W'(b);
					if (kept < ntsc_pkg::TAG_LEN)
						kept++;
					if (kept >= ntsc_pkg::TAG_LEN &&
						window == tag_cfg[ntsc_pkg::TAG_W-1:0]) begin
						scan_phase = SCAN_CAPTURE;
						commas = '0;
						kept = ntsc_pkg::CNT_W'(ntsc_pkg::TAG_LEN);
						r = closing_event(ntsc_pkg::EV_FOUND);
						return 1'b1;
					end
				end else if (scan_phase == SCAN_CAPTURE) begin
					if (b == ntsc_pkg::CHAR_NEWLINE) begin
						scan_phase = SCAN_IDLE;
						r = closing_event(ntsc_pkg::EV_END);
						return 1'b1;
					end
					// Drop the byte that would not fit, end the capture
					if (kept >= ntsc_pkg::SENTENCE_MAX - 1) begin
						scan_phase = SCAN_IDLE;
						r = closing_event(ntsc_pkg::EV_OVERFLOW);
						return 1'b1;
					end
					kept++;
					r.event_res = ntsc_pkg::EV_BYTE;
					r.data_byte = b;
					r.field_number = commas;
					r.is_delimiter = (b == ntsc_pkg::CHAR_COMMA);
					r.in_selected = (b != ntsc_pkg::CHAR_COMMA) && (commas == select_cfg);
					if (b == ntsc_pkg::CHAR_COMMA && commas != '1)
						commas++;
					return 1'b1;
				end
			end
			ntsc_pkg::CMD_TICK: begin
				if (scan_phase == SCAN_SEARCH) begin
					if (ticks != '1)
						ticks++;
					if (ticks >= timeout_cfg) begin
						scan_phase = SCAN_IDLE;
						r = closing_event(ntsc_pkg::EV_TIMEOUT);
						return 1'b1;
					end
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			mismatches++;
		end
	endtask

	// Compare result words, track register writes, predict on input words
	always @(posedge clk or negedge arst_n) begin : monitor
		ntsc_pkg::res_t want;
		ntsc_pkg::res_t predicted;
		if (!arst_n) begin
			tag_cfg = ntsc_pkg::TAG_PATTERN_RST;
			timeout_cfg = ntsc_pkg::TIMEOUT_MS_RST;
			select_cfg = ntsc_pkg::FIELD_SELECT_RST;
			scan_phase = SCAN_IDLE;
			window = '0;
			ticks = '0;
			commas = '0;
			kept = '0;
			expected_events.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected result word, event %0d", $time, event_res);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", int'(want.event_res), int'(event_res));
					check_field("data_byte", int'(want.data_byte), int'(data_byte));
					check_field("field_number", int'(want.field_number),
						int'(field_number));
					check_field("is_delimiter", int'(want.is_delimiter),
						int'(is_delimiter));
					check_field("in_selected", int'(want.in_selected), int'(in_selected));
					check_field("last", int'(want.last), int'(last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ntsc_pkg::CFG_TAG_PATTERN:  tag_cfg = cfg_data;
					ntsc_pkg::CFG_TIMEOUT_MS:   timeout_cfg = cfg_data[ntsc_pkg::TIMEOUT_W-1:0];
					ntsc_pkg::CFG_FIELD_SELECT: select_cfg = cfg_data[ntsc_pkg::FIELD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (capture_step(command, rx_byte, predicted))
					expected_events.push_back(predicted);
			end
			outstanding = expected_events.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int         CLK_PERIOD     = 12;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam int         DRAIN_CYCLES   = 6;
	localparam int         RANDOM_WORDS   = 1350;
	localparam int         LONG_TIMEOUT   = 200;
	localparam logic [1:0] CMD_UNUSED     = 2'd3;
	localparam logic [1:0] CFG_UNUSED     = 2'd3;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [4:0]  field_number;
	logic        is_delimiter;
	logic        in_selected;
	logic        last;
	int          outstanding;
	int          mismatches;

	int                             words_sent;
	int                             burst_left;
	bit                             steady_sender;
	int                             quiet_cycles;
	rx_mode_t                       rx_mode;
	int                             rx_count;
	logic [ntsc_pkg::PATTERN_W-1:0] tag_now;
	logic [ntsc_pkg::TIMEOUT_W-1:0] timeout_now;

	nmea_tag_sentence_capture uut (.*);

	capture_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Stall the result side in one of four modes, picked anew when the mode counter runs out
	always @(negedge clk) begin
		if (rx_count == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_count = $urandom_range(50, 300);
		end
		rx_count--;
		case (rx_mode)
			RX_FREE:  out_ready = 1'b1;
			RX_LIGHT: out_ready = ($urandom_range(0, 3) != 0);
			RX_HEAVY: out_ready = ($urandom_range(0, 3) == 0);
			default:  out_ready = ((rx_count % 16) < 4);
		endcase
	end

	// End the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Offer one input word, idling between bursts, and hold it until taken
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid = 1'b1;
		command = cmd;
		rx_byte = b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold the input until every predicted event is out, then let the pipe settle
	task automatic drain_all();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_tag(input logic [ntsc_pkg::PATTERN_W-1:0] tag, input int n);
		for (int i = 0; i < n; i++)
			send_word(ntsc_pkg::CMD_BYTE, tag[ntsc_pkg::PATTERN_W-1-8*i -: 8]);
	endtask

	// Sentence body without newline; sprinkle ignored ticks and unused commands
	task automatic send_body(input int len, input int comma_pct);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 39) == 0)
				send_word(($urandom_range(0, 1) != 0) ? ntsc_pkg::CMD_TICK : CMD_UNUSED,
					8'($urandom_range(0, 255)));
			b = ($urandom_range(1, 100) <= comma_pct) ? ntsc_pkg::CHAR_COMMA :
				8'($urandom_range(0, 255));
			if (b == ntsc_pkg::CHAR_NEWLINE)
				b = "*";
			send_word(ntsc_pkg::CMD_BYTE, b);
		end
	endtask

	// Pick and write a fresh register setting, garbage in the unused data bits
	task automatic configure_random();
		logic [47:0] data;
		case ($urandom_range(0, 4))
			0:       tag_now = ntsc_pkg::TAG_PATTERN_RST;
			1:       tag_now = '0;
			2:       tag_now = '1;
			default: tag_now = 48'({$urandom(), $urandom()});
		endcase
		case ($urandom_range(0, 9))
			0:       timeout_now = '0;
			1:       timeout_now = 16'd1;
			2:       timeout_now = '1;
			3:       timeout_now = 16'($urandom_range(0, 65535));
			default: timeout_now = 16'($urandom_range(2, 40));
		endcase
		write_reg(ntsc_pkg::CFG_TAG_PATTERN, tag_now);
		data = 48'({$urandom(), $urandom()});
		data[ntsc_pkg::TIMEOUT_W-1:0] = timeout_now;
		write_reg(ntsc_pkg::CFG_TIMEOUT_MS, data);
		data = 48'({$urandom(), $urandom()});
		case ($urandom_range(0, 5))
			0:       data[ntsc_pkg::FIELD_W-1:0] = '0;
			1:       data[ntsc_pkg::FIELD_W-1:0] = '1;
			default: data[ntsc_pkg::FIELD_W-1:0] = 5'($urandom_range(0, 12));
		endcase
		write_reg(ntsc_pkg::CFG_FIELD_SELECT, data);
	endtask

	// Start, a little noise, the tag, a body and usually a newline
	task automatic send_sentence();
		int len;
		int pct;
		int pick;
		send_word(ntsc_pkg::CMD_START, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3))
			send_word(($urandom_range(0, 3) == 0) ? ntsc_pkg::CMD_TICK : ntsc_pkg::CMD_BYTE,
				8'($urandom_range(0, 255)));
		send_tag(tag_now, ntsc_pkg::TAG_LEN);
		pick = $urandom_range(0, 19);
		if (pick < 15) begin
			len = $urandom_range(0, 30);
			pct = $urandom_range(5, 40);
		end else if (pick < 18) begin
			len = $urandom_range(110, 126);
			pct = $urandom_range(5, 30);
		end else begin
			len = $urandom_range(50, 80);
			pct = 70;
		end
		send_body(len, pct);
		case ($urandom_range(0, 9))
			0: ;
			1: send_word(ntsc_pkg::CMD_START, 8'($urandom_range(0, 255)));
			default: send_word(ntsc_pkg::CMD_BYTE, ntsc_pkg::CHAR_NEWLINE);
		endcase
	endtask

	// Start, part of the tag, then ticks toward the timeout
	task automatic send_broken_search();
		int n;
		send_word(ntsc_pkg::CMD_START, 8'($urandom_range(0, 255)));
		send_tag(tag_now, $urandom_range(1, ntsc_pkg::TAG_LEN - 1));
		n = (timeout_now <= 40) ? int'(timeout_now) + $urandom_range(0, 1) : $urandom_range(1, 5);
		repeat (n) send_word(ntsc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int phase_goal;
		int random_goal;
		int pick;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ntsc_pkg::CFG_TAG_PATTERN;
		cfg_data = '0;
		in_valid = 1'b0;
		command = ntsc_pkg::CMD_START;
		rx_byte = '0;
		out_ready = 1'b0;
		words_sent = 0;
		burst_left = 0;
		steady_sender = 1'b0;
		quiet_cycles = 0;
		rx_mode = RX_FREE;
		rx_count = 0;
		tag_now = ntsc_pkg::TAG_PATTERN_RST;
		timeout_now = ntsc_pkg::TIMEOUT_MS_RST;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Default registers: ignored words, restart while capturing, both ends
		send_word(ntsc_pkg::CMD_BYTE, "A");
		send_word(ntsc_pkg::CMD_TICK, 8'h00);
		send_word(CMD_UNUSED, 8'hFF);
		send_word(ntsc_pkg::CMD_START, 8'h00);
		send_word(ntsc_pkg::CMD_TICK, 8'h00);
		send_word(CMD_UNUSED, 8'h00);
		send_tag(ntsc_pkg::TAG_PATTERN_RST, ntsc_pkg::TAG_LEN);
		send_word(ntsc_pkg::CMD_TICK, 8'h00);
		send_word(CMD_UNUSED, 8'h55);
		send_word(ntsc_pkg::CMD_BYTE, "x");
		send_word(ntsc_pkg::CMD_BYTE, ntsc_pkg::CHAR_COMMA);
		send_word(ntsc_pkg::CMD_BYTE, 8'hFF);
		send_word(ntsc_pkg::CMD_BYTE, 8'h00);
		send_word(ntsc_pkg::CMD_START, 8'hAA);
		send_tag(ntsc_pkg::TAG_PATTERN_RST, ntsc_pkg::TAG_LEN);
		send_word(ntsc_pkg::CMD_BYTE, ntsc_pkg::CHAR_NEWLINE);
		send_word(ntsc_pkg::CMD_BYTE, "B");
		drain_all();

		// Zero timeout, all-zero tag, last field selected, write to a spare index
		write_reg(CFG_UNUSED, 48'({$urandom(), $urandom()}));
		write_reg(ntsc_pkg::CFG_TIMEOUT_MS, '0);
		write_reg(ntsc_pkg::CFG_TAG_PATTERN, '0);
		write_reg(ntsc_pkg::CFG_FIELD_SELECT, '1);
		tag_now = '0;
		send_word(ntsc_pkg::CMD_START, 8'h00);
		send_word(ntsc_pkg::CMD_TICK, 8'h00);
		send_word(ntsc_pkg::CMD_START, 8'h00);
		send_tag(tag_now, ntsc_pkg::TAG_LEN);
		send_word(ntsc_pkg::CMD_BYTE, ntsc_pkg::CHAR_COMMA);
		send_word(ntsc_pkg::CMD_BYTE, "x");
		send_word(ntsc_pkg::CMD_BYTE, ntsc_pkg::CHAR_NEWLINE);
		drain_all();

		// Long timeout: run the tick count all the way up to it
		write_reg(ntsc_pkg::CFG_TIMEOUT_MS, 48'(LONG_TIMEOUT));
		steady_sender = 1'b1;
		send_word(ntsc_pkg::CMD_START, 8'h00);
		repeat (LONG_TIMEOUT) send_word(ntsc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		drain_all();

		// Random phases, each under a fresh register setting
		random_goal = words_sent + RANDOM_WORDS;
		while (words_sent < random_goal) begin
			configure_random();
			steady_sender = ($urandom_range(0, 3) == 0);
			phase_goal = words_sent + $urandom_range(60, 250);
			while (words_sent < phase_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					send_sentence();
				else if (pick < 85)
					send_broken_search();
				else
					repeat ($urandom_range(1, 6))
						send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
			drain_all();
		end

		drain_all();
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[nmea_tag_sentence_capture.f]
hdl/ntsc_pkg.sv
hdl/ntsc_cfg_regs.sv
hdl/ntsc_core.sv
hdl/ntsc_out_fifo.sv
hdl/nmea_tag_sentence_capture.sv
sim/capture_checker.sv
sim/tb_top.sv
